### hdl/vfsa_pkg.sv
// Shared types, codes and face lookup functions for the voxel face shading analyzer.
package vfsa_pkg;

	localparam int CELL_COUNT = 27;
	localparam int LAST_CELL  = CELL_COUNT - 1;
	localparam int SUM_W      = 13;
	localparam int MAG_W      = 12;
	localparam int QUO_W      = 7;
	localparam int DIV_STEPS  = QUO_W;
	localparam int REM_W      = MAG_W + QUO_W;
	localparam int DIV_W      = MAG_W + QUO_W - 1;
	localparam int FACE_COUNT = 6;
	localparam int CENTER_IDX = 13;

	localparam logic [7:0] RESET_THRESHOLD = 8'd127;

	localparam logic [2:0] FACE_NEG_Y = 3'd0;
	localparam logic [2:0] FACE_POS_Y = 3'd1;
	localparam logic [2:0] FACE_NEG_Z = 3'd2;
	localparam logic [2:0] FACE_POS_Z = 3'd3;
	localparam logic [2:0] FACE_POS_X = 3'd4;
	localparam logic [2:0] FACE_NEG_X = 3'd5;

	typedef struct packed {
		logic [7:0] alpha;
		logic       first;
	} item_t;

	typedef struct packed {
		logic [2:0]        face;
		logic              visible;
		logic signed [7:0] gradient_x;
		logic signed [7:0] gradient_y;
		logic signed [7:0] gradient_z;
		logic [7:0]        occlusion_mask;
		logic              last;
	} result_t;

	// Controller to datapath.
	typedef struct packed {
		logic       load;
		logic       mag;
		logic       div;
		logic       emit;
		logic       clear;
		logic [2:0] face;
	} cmd_t;

	// Datapath to controller.
	typedef struct packed {
		logic complete;
	} status_t;

	typedef struct packed {
		logic [3:0][26:0] corner;
		logic [3:0][26:0] side;
		logic [26:0]      across;
	} face_mask_t;

	typedef struct packed {
		logic signed [7:0] x;
		logic signed [7:0] y;
		logic signed [7:0] z;
	} normal_t;

	function automatic logic [26:0] vb(input int x, input int y, input int z);
		return 27'(1) << ((x + 1) + (y + 1) * 3 + (z + 1) * 9);
	endfunction

	function automatic face_mask_t face_masks(input logic [2:0] f);
		face_mask_t m;
		m = '0;
		case (f)
			FACE_NEG_Y: begin
				m.across    = vb(0, -1, 0);
				m.side[0]   = vb(0, -1, -1);
				m.side[1]   = vb(1, -1, 0);
				m.side[2]   = vb(0, -1, 1);
				m.side[3]   = vb(-1, -1, 0);
				m.corner[0] = vb(-1, -1, 0) | vb(0, -1, -1) | vb(-1, -1, -1);
				m.corner[1] = vb(0, -1, -1) | vb(1, -1, 0) | vb(1, -1, -1);
				m.corner[2] = vb(1, -1, 0) | vb(0, -1, 1) | vb(1, -1, 1);
				m.corner[3] = vb(0, -1, 1) | vb(-1, -1, 0) | vb(-1, -1, 1);
			end
			FACE_POS_Y: begin
				m.across    = vb(0, 1, 0);
				m.side[0]   = vb(0, 1, -1);
				m.side[1]   = vb(-1, 1, 0);
				m.side[2]   = vb(0, 1, 1);
				m.side[3]   = vb(1, 1, 0);
				m.corner[0] = vb(1, 1, 0) | vb(0, 1, -1) | vb(1, 1, -1);
				m.corner[1] = vb(0, 1, -1) | vb(-1, 1, 0) | vb(-1, 1, -1);
				m.corner[2] = vb(-1, 1, 0) | vb(0, 1, 1) | vb(-1, 1, 1);
				m.corner[3] = vb(0, 1, 1) | vb(1, 1, 0) | vb(1, 1, 1);
			end
			FACE_NEG_Z: begin
				m.across    = vb(0, 0, -1);
				m.side[0]   = vb(-1, 0, -1);
				m.side[1]   = vb(0, 1, -1);
				m.side[2]   = vb(1, 0, -1);
				m.side[3]   = vb(0, -1, -1);
				m.corner[0] = vb(0, -1, -1) | vb(-1, 0, -1) | vb(-1, -1, -1);
				m.corner[1] = vb(-1, 0, -1) | vb(0, 1, -1) | vb(-1, 1, -1);
				m.corner[2] = vb(0, 1, -1) | vb(1, 0, -1) | vb(1, 1, -1);
				m.corner[3] = vb(1, 0, -1) | vb(0, -1, -1) | vb(1, -1, -1);
			end
			FACE_POS_Z: begin
				m.across    = vb(0, 0, 1);
				m.side[0]   = vb(1, 0, 1);
				m.side[1]   = vb(0, 1, 1);
				m.side[2]   = vb(-1, 0, 1);
				m.side[3]   = vb(0, -1, 1);
				m.corner[0] = vb(0, -1, 1) | vb(1, 0, 1) | vb(1, -1, 1);
				m.corner[1] = vb(1, 0, 1) | vb(0, 1, 1) | vb(1, 1, 1);
				m.corner[2] = vb(0, 1, 1) | vb(-1, 0, 1) | vb(-1, 1, 1);
				m.corner[3] = vb(-1, 0, 1) | vb(0, -1, 1) | vb(-1, -1, 1);
			end
			FACE_POS_X: begin
				m.across    = vb(1, 0, 0);
				m.side[0]   = vb(1, 0, -1);
				m.side[1]   = vb(1, 1, 0);
				m.side[2]   = vb(1, 0, 1);
				m.side[3]   = vb(1, -1, 0);
				m.corner[0] = vb(1, -1, 0) | vb(1, 0, -1) | vb(1, -1, -1);
				m.corner[1] = vb(1, 0, -1) | vb(1, 1, 0) | vb(1, 1, -1);
				m.corner[2] = vb(1, 1, 0) | vb(1, 0, 1) | vb(1, 1, 1);
				m.corner[3] = vb(1, 0, 1) | vb(1, -1, 0) | vb(1, -1, 1);
			end
			FACE_NEG_X: begin
				m.across    = vb(-1, 0, 0);
				m.side[0]   = vb(-1, -1, 0);
				m.side[1]   = vb(-1, 0, 1);
				m.side[2]   = vb(-1, 1, 0);
				m.side[3]   = vb(-1, 0, -1);
				m.corner[0] = vb(-1, 0, -1) | vb(-1, -1, 0) | vb(-1, -1, -1);
				m.corner[1] = vb(-1, -1, 0) | vb(-1, 0, 1) | vb(-1, -1, 1);
				m.corner[2] = vb(-1, 0, 1) | vb(-1, 1, 0) | vb(-1, 1, 1);
				m.corner[3] = vb(-1, 1, 0) | vb(-1, 0, -1) | vb(-1, 1, -1);
			end
			default: m = '0;
		endcase
		return m;
	endfunction

	function automatic normal_t face_normal(input logic [2:0] f);
		normal_t n;
		n = '0;
		case (f)
			FACE_NEG_Y: n.y = -8'sd1;
			FACE_POS_Y: n.y = 8'sd1;
			FACE_NEG_Z: n.z = -8'sd1;
			FACE_POS_Z: n.z = 8'sd1;
			FACE_POS_X: n.x = 8'sd1;
			FACE_NEG_X: n.x = -8'sd1;
			default:    n = '0;
		endcase
		return n;
	endfunction

endpackage

### hdl/vfsa_ctrl.sv
// Sequencing state machine: gradient scaling steps and the six face transfers.
module vfsa_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  vfsa_pkg::status_t status,
	output vfsa_pkg::cmd_t   cmd,
	output logic             busy
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MAG,
		ST_DIV,
		ST_EMIT
	} state_t;

	state_t     state_q;
	logic [2:0] step_q;

	always_comb begin
		cmd       = '0;
		cmd.load  = start && (state_q == ST_IDLE);
		cmd.mag   = (state_q == ST_MAG);
		cmd.div   = (state_q == ST_DIV);
		cmd.emit  = (state_q == ST_EMIT);
		cmd.clear = (state_q == ST_EMIT) && (step_q == 3'(vfsa_pkg::FACE_COUNT - 1));
		cmd.face  = step_q;
	end

	assign busy = (state_q != ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cmd.load && status.complete) begin
						state_q <= ST_MAG;
					end
				end
				ST_MAG: begin
					state_q <= ST_DIV;
					step_q  <= 3'(vfsa_pkg::DIV_STEPS - 1);
				end
				ST_DIV: begin
					if (step_q == '0) begin
						state_q <= ST_EMIT;
					end else begin
						step_q <= step_q - 3'd1;
					end
				end
				ST_EMIT: begin
					if (step_q == 3'(vfsa_pkg::FACE_COUNT - 1)) begin
						state_q <= ST_IDLE;
						step_q  <= '0;
					end else begin
						step_q <= step_q + 3'd1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
					step_q  <= '0;
				end
			endcase
		end
	end

endmodule

### hdl/vfsa_dp.sv
// Datapath: neighborhood accumulation, three restoring dividers and face result register.
module vfsa_dp (
	input  logic              clk,
	input  logic              arst_n,
	input  vfsa_pkg::item_t   item,
	input  vfsa_pkg::cmd_t    cmd,
	input  logic              cfg_write,
	input  logic [7:0]        cfg_data,
	output vfsa_pkg::status_t status,
	output vfsa_pkg::result_t result,
	output logic              result_valid
);

	logic [7:0]                               threshold_q;
	logic [26:0]                              solid_q;
	logic signed [vfsa_pkg::SUM_W-1:0]        sum_q [3];
	logic [4:0]                               cnt_q;
	logic [1:0]                               pos_q [3];

	logic [vfsa_pkg::REM_W-1:0]               rem_q [3];
	logic [vfsa_pkg::QUO_W-1:0]               quo_q [3];
	logic                                     neg_q [3];
	logic [vfsa_pkg::DIV_W-1:0]               div_q;
	logic                                     mzero_q;

	vfsa_pkg::result_t                        result_q;
	logic                                     valid_q;

	// Item intake.
	logic [4:0]                               idx;
	logic [26:0]                              solid_base;
	logic signed [vfsa_pkg::SUM_W-1:0]        sum_base [3];
	logic signed [vfsa_pkg::SUM_W-1:0]        sum_next [3];
	logic [1:0]                               pos_base [3];
	logic                                     is_solid;
	logic signed [vfsa_pkg::SUM_W-1:0]        alpha_ext;

	// Scaling.
	logic [vfsa_pkg::MAG_W-1:0]               mag_v [3];
	logic [vfsa_pkg::MAG_W-1:0]               mag_max;
	logic [vfsa_pkg::REM_W:0]                 trial [3];
	logic signed [7:0]                        grad [3];

	// Face result.
	vfsa_pkg::face_mask_t                     fm;
	vfsa_pkg::normal_t                        fn;
	logic [7:0]                               occ;

	always_comb begin
		idx        = item.first ? 5'd0 : cnt_q;
		solid_base = item.first ? 27'd0 : solid_q;
		is_solid   = (item.alpha >= threshold_q);
		alpha_ext  = $signed({{(vfsa_pkg::SUM_W - 8){1'b0}}, item.alpha});
		for (int a = 0; a < 3; a++) begin
			sum_base[a] = item.first ? '0 : sum_q[a];
			pos_base[a] = item.first ? 2'd0 : pos_q[a];
			// A solid byte at offset -1 adds alpha, at +1 subtracts it.
			if (is_solid && pos_base[a] == 2'd0) begin
				sum_next[a] = sum_base[a] + alpha_ext;
			end else if (is_solid && pos_base[a] == 2'd2) begin
				sum_next[a] = sum_base[a] - alpha_ext;
			end else begin
				sum_next[a] = sum_base[a];
			end
		end
		status.complete = (idx == 5'(vfsa_pkg::LAST_CELL));
	end

	always_comb begin
		for (int a = 0; a < 3; a++) begin
			mag_v[a] = sum_q[a][vfsa_pkg::SUM_W-1] ?
				vfsa_pkg::MAG_W'(-sum_q[a]) : vfsa_pkg::MAG_W'(sum_q[a]);
			trial[a] = {1'b0, rem_q[a]} - (vfsa_pkg::REM_W + 1)'(div_q);
			grad[a]  = neg_q[a] ? -$signed({1'b0, quo_q[a]}) : $signed({1'b0, quo_q[a]});
		end
		mag_max = mag_v[0];
		if (mag_v[1] > mag_max) begin
			mag_max = mag_v[1];
		end
		if (mag_v[2] > mag_max) begin
			mag_max = mag_v[2];
		end
	end

	always_comb begin
		fm  = vfsa_pkg::face_masks(cmd.face);
		fn  = vfsa_pkg::face_normal(cmd.face);
		occ = '0;
		for (int k = 0; k < 4; k++) begin
			occ[k]     = |(solid_q & fm.corner[k]);
			occ[4 + k] = |(solid_q & fm.side[k]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= vfsa_pkg::RESET_THRESHOLD;
			solid_q     <= '0;
			cnt_q       <= '0;
			for (int a = 0; a < 3; a++) begin
				sum_q[a] <= '0;
				pos_q[a] <= '0;
			end
			valid_q     <= 1'b0;
		end else begin
			valid_q <= cmd.emit;
			if (cfg_write) begin
				threshold_q <= cfg_data;
			end
			if (cmd.clear) begin
				solid_q <= '0;
				cnt_q   <= '0;
				for (int a = 0; a < 3; a++) begin
					sum_q[a] <= '0;
					pos_q[a] <= '0;
				end
			end else if (cmd.load) begin
				solid_q <= solid_base | (27'(is_solid) << idx);
				cnt_q   <= idx + 5'd1;
				for (int a = 0; a < 3; a++) begin
					sum_q[a] <= sum_next[a];
				end
				// x runs fastest, then y, then z.
				pos_q[0] <= (pos_base[0] == 2'd2) ? 2'd0 : pos_base[0] + 2'd1;
				if (pos_base[0] == 2'd2) begin
					pos_q[1] <= (pos_base[1] == 2'd2) ? 2'd0 : pos_base[1] + 2'd1;
					if (pos_base[1] == 2'd2) begin
						pos_q[2] <= pos_base[2] + 2'd1;
					end else begin
						pos_q[2] <= pos_base[2];
					end
				end else begin
					pos_q[1] <= pos_base[1];
					pos_q[2] <= pos_base[2];
				end
			end
		end
	end

	// Divider lanes: |sum| * 127 / max, one quotient bit per step.
	always_ff @(posedge clk) begin
		if (cmd.mag) begin
			div_q   <= {mag_max, {(vfsa_pkg::QUO_W - 1){1'b0}}};
			mzero_q <= (mag_max == '0);
			for (int a = 0; a < 3; a++) begin
				rem_q[a] <= {mag_v[a], {vfsa_pkg::QUO_W{1'b0}}}
					- vfsa_pkg::REM_W'(mag_v[a]);
				quo_q[a] <= '0;
				neg_q[a] <= sum_q[a][vfsa_pkg::SUM_W-1];
			end
		end else if (cmd.div) begin
			div_q <= div_q >> 1;
			for (int a = 0; a < 3; a++) begin
				if (!trial[a][vfsa_pkg::REM_W]) begin
					rem_q[a] <= trial[a][vfsa_pkg::REM_W-1:0];
					quo_q[a] <= {quo_q[a][vfsa_pkg::QUO_W-2:0], 1'b1};
				end else begin
					quo_q[a] <= {quo_q[a][vfsa_pkg::QUO_W-2:0], 1'b0};
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			result_q.face           <= cmd.face;
			result_q.visible        <= solid_q[vfsa_pkg::CENTER_IDX] && !(|(solid_q & fm.across));
			result_q.gradient_x     <= mzero_q ? fn.x : grad[0];
			result_q.gradient_y     <= mzero_q ? fn.y : grad[1];
			result_q.gradient_z     <= mzero_q ? fn.z : grad[2];
			result_q.occlusion_mask <= occ;
			result_q.last           <= (cmd.face == vfsa_pkg::FACE_NEG_X);
		end
	end

	assign result       = result_q;
	assign result_valid = valid_q;

endmodule

### hdl/voxel_face_shading_analyzer.sv
// Top level of the voxel face shading analyzer.
//
// Neighborhood bytes arrive on item: a transfer happens at a clock edge where
// start is high and busy is low. item.first restarts the 3x3x3 neighborhood;
// after the 27th byte the next byte starts a new one regardless of first.
// A byte that does not complete a neighborhood leaves busy low.
// The 27th byte raises busy while the controller steps through ST_MAG,
// which finds the largest gradient magnitude, ST_DIV, which runs three
// restoring dividers in parallel (one quotient bit per cycle), and ST_EMIT,
// which produces the faces. The six face results leave on result, one per
// cycle, each marked by result_valid for exactly one cycle; each result is
// registered from ST_EMIT, and result.last marks the sixth. The receiver
// has no way to stall and must take every result.
// The threshold register is written through cfg_valid/cfg_ready/cfg_data,
// accepted whenever busy is low. Reset clears the neighborhood and sets the
// threshold to 127.
module voxel_face_shading_analyzer (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  vfsa_pkg::item_t   item,
	output vfsa_pkg::result_t result,
	output logic              result_valid,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [7:0]        cfg_data
);

	vfsa_pkg::cmd_t    cmd;
	vfsa_pkg::status_t status;

	assign cfg_ready = !busy;

	vfsa_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.status (status),
		.cmd    (cmd),
		.busy   (busy)
	);

	vfsa_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.item         (item),
		.cmd          (cmd),
		.cfg_write    (cfg_valid && cfg_ready),
		.cfg_data     (cfg_data),
		.status       (status),
		.result       (result),
		.result_valid (result_valid)
	);

endmodule
